@@ rtl/core/keyword_value_field_extractor_macros.svh @@
// ----------------------------------------------------------------------------
// keyword_value_field_extractor_macros.svh
// Assertion macros shared by the keyword value field extractor.
// ----------------------------------------------------------------------------
`ifndef KEYWORD_VALUE_FIELD_EXTRACTOR_MACROS_SVH
`define KEYWORD_VALUE_FIELD_EXTRACTOR_MACROS_SVH

// Same-cycle implication, checked outside reset
`define KVFE_ASSERT_NOW(name, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define KVFE_ASSERT_NEXT(name, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

@@ rtl/core/kvfe_pkg.sv @@
// ----------------------------------------------------------------------------
// kvfe_pkg
// Types, character codes and sizes for the keyword value field extractor.
// ----------------------------------------------------------------------------
package kvfe_pkg;

  // Default keyword window depth in bytes
  localparam int KEYWORD_BYTES_DEF = 8;

  // Most results one item can cause, and the result queue size
  localparam int MAX_RESULTS = 3;
  localparam int RES_DEPTH   = 8;
  localparam int RES_PTR_W   = $clog2(RES_DEPTH);
  localparam int RES_CNT_W   = $clog2(RES_DEPTH + 1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_CHARS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIP     = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_VALUE    = 2'd0;
  localparam logic [1:0] KIND_COMPLETE = 2'd1;
  localparam logic [1:0] KIND_NOTFOUND = 2'd2;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;

  typedef enum logic [2:0] {
    PH_SEARCH,
    PH_HOLD,
    PH_SKIP,
    PH_VALUE,
    PH_REST,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] label_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] out_kind;
    logic       run_end;
  } out_item_t;

  typedef struct packed {
    logic [63:0] key_chars;
    logic [3:0]  key_size;
    logic        strip;
  } cfg_t;

  // Results of one item, in order, toward the result queue
  typedef struct packed {
    logic [1:0]                        count;
    out_item_t [MAX_RESULTS-1:0]       slot;
  } push_t;

endpackage

@@ rtl/core/kvfe_scan.sv @@
// ----------------------------------------------------------------------------
// kvfe_scan
// Per-byte label processing: comment blanking, keyword window search,
// colon check and value emission. Produces up to three results per item.
// ----------------------------------------------------------------------------
module kvfe_scan #(
  parameter int KEYWORD_BYTES = kvfe_pkg::KEYWORD_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  kvfe_pkg::cfg_t    cfg,
  input  logic              advance,
  input  kvfe_pkg::in_item_t item,
  output kvfe_pkg::push_t   push
);
  import kvfe_pkg::*;

  localparam int FILL_W = $clog2(KEYWORD_BYTES + 1);

  logic              ic_r, ic_nxt;
  logic [7:0]        win_r [KEYWORD_BYTES];
  logic [7:0]        win_nxt [KEYWORD_BYTES];
  logic [FILL_W-1:0] fill_r, fill_nxt;
  phase_t            phase_r, phase_nxt;
  logic [7:0]        held_r, held_nxt;
  logic              hc_r, hc_nxt;

  logic [FILL_W-1:0]      key_len;
  logic [KEYWORD_BYTES:0] len_match;
  logic                   win_match;
  push_t                  res;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    upcase = (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
  endfunction

  function automatic logic is_cmt(input logic [7:0] c);
    is_cmt = (c == CH_SEMI) || (c == CH_HASH);
  endfunction

  // Step one byte through the blank skip / value / rest phases
  function automatic phase_t value_step(input phase_t ph, input logic [7:0] c,
                                        output logic emit, output logic [7:0] ob,
                                        output logic [1:0] kind);
    value_step = ph;
    emit       = 1'b0;
    ob         = c;
    kind       = KIND_VALUE;
    case (ph)
      PH_SKIP: begin
        if (!(c == CH_SPACE || c == CH_TAB || c == CH_NL)) begin
          emit       = 1'b1;
          value_step = is_cmt(c) ? PH_REST : PH_VALUE;
        end
      end
      PH_VALUE: begin
        emit = 1'b1;
        if (is_cmt(c) || c == CH_NL) begin
          ob         = CH_NUL;
          kind       = KIND_COMPLETE;
          value_step = PH_DONE;
        end
      end
      PH_REST: emit = 1'b1;
      default: ;
    endcase
  endfunction

  // Effective keyword length: capped, then cut at the first zero byte
  always_comb begin
    logic [FILL_W-1:0] lim;
    if (cfg.key_size > 4'(KEYWORD_BYTES)) lim = FILL_W'(KEYWORD_BYTES);
    else lim = FILL_W'(cfg.key_size);
    key_len = lim;
    for (int i = KEYWORD_BYTES - 1; i >= 0; i--) begin
      if (FILL_W'(i) < lim && cfg.key_chars[8*i +: 8] == CH_NUL) key_len = FILL_W'(i);
    end
  end

  // Compare the newest window bytes against the keyword for every length
  always_comb begin
    len_match[0] = 1'b1;
    for (int l = 1; l <= KEYWORD_BYTES; l++) begin
      len_match[l] = (fill_r >= FILL_W'(l));
      for (int i = 0; i < KEYWORD_BYTES; i++) begin
        if (i < l && win_r[KEYWORD_BYTES - l + i] != upcase(cfg.key_chars[8*i +: 8]))
          len_match[l] = 1'b0;
      end
    end
    win_match = len_match[key_len];
  end

  // Next label state and the results of this item
  always_comb begin
    logic [7:0] c;
    logic [1:0] n;
    logic       emit;
    logic [7:0] ob;
    logic [1:0] kind;
    phase_t     ph;

    c         = item.label_byte;
    n         = 2'd0;
    emit      = 1'b0;
    ob        = CH_NUL;
    kind      = KIND_VALUE;
    ph        = phase_r;
    ic_nxt    = ic_r;
    win_nxt   = win_r;
    fill_nxt  = fill_r;
    held_nxt  = held_r;
    hc_nxt    = hc_r;
    res       = '0;

    // Blank comment text
    if (cfg.strip) begin
      if (c == CH_NL) ic_nxt = 1'b0;
      else if (is_cmt(c)) ic_nxt = 1'b1;
      else if (ic_r) c = CH_SPACE;
    end

    if (ph != PH_DONE) begin
      if (c == CH_NUL) begin
        // Zero byte ends the text
        res.slot[n] = '{out_byte: CH_NUL, run_end: 1'b0,
                        out_kind: (ph == PH_SEARCH || ph == PH_HOLD) ?
                                  KIND_NOTFOUND : KIND_COMPLETE};
        n  = n + 2'd1;
        ph = PH_DONE;
      end else begin
        case (ph)
          PH_SEARCH: begin
            if (win_match) begin
              if (c == CH_COLON) begin
                ph     = PH_HOLD;
                hc_nxt = 1'b0;
              end else begin
                fill_nxt = '0;
              end
            end else begin
              for (int i = 0; i < KEYWORD_BYTES - 1; i++) win_nxt[i] = win_r[i + 1];
              win_nxt[KEYWORD_BYTES - 1] = upcase(c);
              if (fill_r < FILL_W'(KEYWORD_BYTES)) fill_nxt = fill_r + 1'b1;
            end
          end
          PH_HOLD: begin
            if (!hc_r) begin
              held_nxt = c;
              hc_nxt   = 1'b1;
            end else begin
              // Two bytes follow the colon: release both
              hc_nxt = 1'b0;
              ph     = value_step(PH_SKIP, held_r, emit, ob, kind);
              if (emit) begin
                res.slot[n] = '{out_byte: ob, out_kind: kind, run_end: 1'b0};
                n = n + 2'd1;
              end
              ph = value_step(ph, c, emit, ob, kind);
              if (emit) begin
                res.slot[n] = '{out_byte: ob, out_kind: kind, run_end: 1'b0};
                n = n + 2'd1;
              end
            end
          end
          default: begin
            ph = value_step(ph, c, emit, ob, kind);
            if (emit) begin
              res.slot[n] = '{out_byte: ob, out_kind: kind, run_end: 1'b0};
              n = n + 2'd1;
            end
          end
        endcase
      end
    end

    // End of label: report and return to the label start state
    if (item.final_byte) begin
      if (ph != PH_DONE) begin
        res.slot[n] = '{out_byte: CH_NUL, run_end: 1'b0,
                        out_kind: (ph == PH_SEARCH || ph == PH_HOLD) ?
                                  KIND_NOTFOUND : KIND_COMPLETE};
        n = n + 2'd1;
      end
      ph       = PH_SEARCH;
      ic_nxt   = 1'b0;
      fill_nxt = '0;
      hc_nxt   = 1'b0;
    end

    // Flag the last result of the item
    if (n != 2'd0) res.slot[n - 2'd1].run_end = 1'b1;

    res.count = advance ? n : 2'd0;
    phase_nxt = ph;
  end

  assign push = res;

  // Hold label state, advance on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ic_r    <= 1'b0;
      fill_r  <= '0;
      phase_r <= PH_SEARCH;
      hc_r    <= 1'b0;
    end else if (advance) begin
      ic_r    <= ic_nxt;
      fill_r  <= fill_nxt;
      phase_r <= phase_nxt;
      hc_r    <= hc_nxt;
    end
  end

  // Window and held byte carry payload only
  always_ff @(posedge clk) begin
    if (advance) begin
      win_r  <= win_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

@@ rtl/core/kvfe_fifo.sv @@
// ----------------------------------------------------------------------------
// kvfe_fifo
// Result queue: takes up to three results per cycle, hands out one.
// ----------------------------------------------------------------------------
module kvfe_fifo (
  input  logic                            clk,
  input  logic                            rst_n,
  input  kvfe_pkg::push_t                 push,
  input  logic                            pop,
  output logic                            out_valid,
  output kvfe_pkg::out_item_t             head,
  output logic [kvfe_pkg::RES_CNT_W-1:0]  count
);
  import kvfe_pkg::*;

  out_item_t             mem [RES_DEPTH];
  logic [RES_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [RES_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [RES_CNT_W-1:0]  count_r, count_nxt;

  assign out_valid = (count_r != '0);
  assign head      = mem[rd_ptr_r];
  assign count     = count_r;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + RES_PTR_W'(push.count);
    rd_ptr_nxt = rd_ptr_r + RES_PTR_W'(pop);
    count_nxt  = count_r + RES_CNT_W'(push.count) - RES_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Write the item's results at consecutive slots
  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_RESULTS; j++) begin
      if (2'(j) < push.count) mem[wr_ptr_r + RES_PTR_W'(j)] <= push.slot[j];
    end
  end

endmodule

@@ rtl/core/keyword_value_field_extractor.sv @@
// ----------------------------------------------------------------------------
// keyword_value_field_extractor
// Finds a configured keyword followed by a colon in a byte stream and
// returns the value bytes after it, with optional comment blanking.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall  in_item_t: label_byte, final_byte
// out_     output     out_valid/out_stall out_item_t: out_byte, out_kind, run_end
// cfg_     input      cfg_valid/cfg_ready index (2 bits), data (64 bits)
//
// An item enters the input register, is processed combinationally and its
// results (zero to three) land in an eight-entry result queue.
// One byte per cycle sustained while results drain one per cycle; the
// input stalls while the queue has fewer than three free entries.
// Results pass through the input register and then the result queue.
// Synchronous reset clears control state; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "keyword_value_field_extractor_macros.svh"

module keyword_value_field_extractor #(
  parameter int KEYWORD_BYTES = kvfe_pkg::KEYWORD_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  kvfe_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output kvfe_pkg::out_item_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [kvfe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [63:0]                      cfg_data
);
  import kvfe_pkg::*;

  cfg_t                  cfg_r;
  logic                  in_valid_r;
  in_item_t              in_item_r;
  logic                  room;
  logic                  advance;
  push_t                 push;
  logic [RES_CNT_W-1:0]  res_count;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key_chars <= '0;
      cfg_r.key_size  <= 4'd1;
      cfg_r.strip     <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_KEY_CHARS: cfg_r.key_chars <= cfg_data;
        CFG_KEY_SIZE:  cfg_r.key_size  <= cfg_data[3:0];
        CFG_STRIP:     cfg_r.strip     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register: advance when the queue can take a full item's results
  assign room     = (res_count <= RES_CNT_W'(RES_DEPTH - MAX_RESULTS));
  assign advance  = in_valid_r && room;
  assign in_stall = in_valid_r && !room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_item_r <= in_data;
  end

  kvfe_scan #(
    .KEYWORD_BYTES (KEYWORD_BYTES)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .advance (advance),
    .item    (in_item_r),
    .push    (push)
  );

  kvfe_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (out_valid && !out_stall),
    .out_valid (out_valid),
    .head      (out_data),
    .count     (res_count)
  );

  // Checks
  `KVFE_ASSERT_NOW(a_queue_bound, 1'b1, res_count <= RES_CNT_W'(RES_DEPTH), "result queue overflow")
  `KVFE_ASSERT_NEXT(a_item_held, in_valid_r && !advance, in_valid_r, "stalled item lost")
  `KVFE_ASSERT_NOW(a_push_gated, !advance, push.count == 2'd0, "results pushed without an item")

endmodule
